// ===== rtl/core/waypoint_segment_feasibility_check_macros.svh =====
// Assertion helpers for the waypoint segment checker.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef WAYPOINT_SEGMENT_FEASIBILITY_CHECK_MACROS_SVH
`define WAYPOINT_SEGMENT_FEASIBILITY_CHECK_MACROS_SVH
`ifndef SYNTHESIS
// Consequence must hold in the same cycle
`define WSFC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("wsfc: same-cycle check failed");
// Consequence must hold in the next cycle
`define WSFC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("wsfc: next-cycle check failed");
`else
`define WSFC_ASSERT_IMP(label, ck, rn, ante, cons)
`define WSFC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/core/wsfc_pkg.sv =====
package wsfc_pkg;

    // Field and register widths
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int ETA_W           = 32;
    localparam int SPEED_W         = 24;
    localparam int DIST_W          = 16;
    localparam int IN_DATA_W       = 4 * FIELD_W;
    localparam int OUT_DATA_W      = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    // Shared multiplier works on 32-bit limbs
    localparam int LIMB_W = 32;

    // ms to s scale, squared
    localparam int               MILLION_W = 20;
    localparam logic [MILLION_W-1:0] MILLION = 20'd1000000;

    // Register reset values
    localparam logic [SPEED_W-1:0] CRUISE_RST = 24'd1280;
    localparam logic [SPEED_W-1:0] CLIMB_RST  = 24'd512;
    localparam logic [SPEED_W-1:0] MIN_RST    = 24'd0;
    localparam logic [SPEED_W-1:0] MAX_RST    = 24'd2560;
    localparam logic [DIST_W-1:0]  NEAR_RST   = 16'd26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAN_IS_4D    = 3'd0,
        REG_CRUISE_SPEED  = 3'd1,
        REG_CLIMB_SPEED   = 3'd2,
        REG_MIN_SPEED     = 3'd3,
        REG_MAX_SPEED     = 3'd4,
        REG_TOO_NEAR_DIST = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CODE_OK     = 2'd0,
        CODE_NEAR   = 2'd1,
        CODE_STEEP  = 2'd2,
        CODE_TIMING = 2'd3
    } seg_code_t;

    // Multiply-accumulate steps of the sequencer
    typedef enum logic [3:0] {
        OP_DX2   = 4'd0,   // dx^2
        OP_DY2   = 4'd1,   // + dy^2, gives d2
        OP_LHS   = 4'd2,   // d2 * 10^6
        OP_DT2   = 4'd3,   // dt^2
        OP_MIN2  = 4'd4,   // min_speed^2
        OP_SLOW  = 4'd5,   // min^2 * dt^2, compare
        OP_MAX2  = 4'd6,   // max_speed^2
        OP_FAST  = 4'd7,   // max^2 * dt^2, compare
        OP_NEAR  = 4'd8,   // too_near^2, compare
        OP_DZ2   = 4'd9,   // dz^2
        OP_CR2   = 4'd10,  // cruise^2
        OP_RISE  = 4'd11,  // dz^2 * cruise^2
        OP_CL2   = 4'd12,  // climb^2
        OP_ALLOW = 4'd13   // climb^2 * d2, compare
    } mac_op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

// ===== rtl/core/waypoint_segment_feasibility_check.sv =====
// Waypoint segment checker: each accepted waypoint closes a segment from the one before and
// yields one result item (checked flag, segment code, plan code). All tests are exact integer
// compares built on one shared 32x32 multiplier that walks limb products into a wide
// accumulator. The wide operand has L = ceil((2*COORD_WIDTH+1)/32) limbs, so L = 3 at the
// default width. An item runs n multiply steps between its acceptance and its result: n = 8
// steps in 2D mode and 14 in 4D mode, fewer when an earlier test already fails; a plan start,
// or a non-positive time step in 4D mode, runs no multiply step. The input side is not ready
// while an item is worked on. A finished result moves to an output register and the next
// waypoint can be taken while it waits there; a result still waiting when the next one is
// finished holds the sequencer until it is taken.
`include "waypoint_segment_feasibility_check_macros.svh"
module waypoint_segment_feasibility_check
    import wsfc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // waypoint items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // wp_x, wp_y, wp_z, wp_eta
    input  logic                  s_axis_tuser,   // plan_start
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // segment_checked, segment_code, plan_code, pad
);

    // Derived widths
    localparam int MAG_W    = COORD_WIDTH;
    localparam int DIF_W    = COORD_WIDTH + 1;
    localparam int D2_W     = 2 * MAG_W + 1;
    localparam int DZ2_W    = 2 * MAG_W;
    localparam int LHS_W    = D2_W + MILLION_W;
    localparam int RISE_W   = DZ2_W + 2 * SPEED_W;
    localparam int ALLOW_W  = D2_W + 2 * SPEED_W;
    localparam int TIME_W   = 2 * SPEED_W + 2 * ETA_W;
    localparam int ACC_W    = (ALLOW_W > TIME_W) ? ALLOW_W : TIME_W;
    localparam int A_LIMBS  = (D2_W + LIMB_W - 1) / LIMB_W;
    localparam int A_W      = A_LIMBS * LIMB_W;
    localparam int B_W      = 2 * LIMB_W;
    localparam int SUM_W    = (A_LIMBS + 2) * LIMB_W;
    localparam int LI_W     = $clog2(A_LIMBS);
    localparam int SH_W     = $clog2(A_LIMBS + 1);
    localparam int LIMB_SH  = $clog2(LIMB_W);
    localparam int T_W      = 2 * SPEED_W;
    localparam int DT2_W    = 2 * ETA_W;

    // Configuration registers
    logic               plan_is_4d_reg;
    logic [SPEED_W-1:0] cruise_speed_reg;
    logic [SPEED_W-1:0] climb_speed_reg;
    logic [SPEED_W-1:0] min_speed_reg;
    logic [SPEED_W-1:0] max_speed_reg;
    logic [DIST_W-1:0]  too_near_dist_reg;

    // Control
    state_t          state_reg, state_next;
    mac_op_t         op_reg, op_next;
    logic            issue_reg, issue_next;
    logic            pv_reg, pv_next;
    logic [LI_W-1:0] li_reg, li_next;
    logic            lj_reg, lj_next;
    logic [1:0]      code_reg, code_next;
    logic            checked_reg, checked_next;
    logic [1:0]      first_error_reg, first_error_next;
    logic            have_prev_reg, have_prev_next;
    logic            m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Waypoint payload
    logic [MAG_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [ETA_W-1:0] prev_eta_reg;
    logic [DIF_W-1:0] dif_x_reg, dif_y_reg, dif_z_reg;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic [ETA_W-1:0] dt_reg;
    logic             dt_pos_reg;
    logic             start_reg;

    // Multiplier datapath and intermediate products
    logic [B_W-1:0]    prod_reg;
    logic [SH_W-1:0]   sh_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic [DT2_W-1:0]  dt2_reg;
    logic [T_W-1:0]    t_reg;
    logic [DZ2_W-1:0]  dz2_reg;
    logic [RISE_W-1:0] rise_reg;

    logic              in_accept;
    logic [MAG_W-1:0]  x_raw, y_raw, z_raw;
    logic [ETA_W-1:0]  eta_raw;
    logic [A_W-1:0]    op_a;
    logic [B_W-1:0]    op_b;
    logic [LIMB_W-1:0] a_limb, b_limb;
    logic [SUM_W-1:0]  shifted;
    mac_op_t           fin_op;
    logic              fin_last;
    seg_code_t         fin_code;
    logic [1:0]        plan_code;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Input fields in the coordinate width (zero-extended above the field)
    assign x_raw   = MAG_W'(s_axis_tdata[FIELD_W-1:0]);
    assign y_raw   = MAG_W'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    assign z_raw   = MAG_W'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
    assign eta_raw = s_axis_tdata[4*FIELD_W-1:3*FIELD_W];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_is_4d_reg    <= 1'b0;
            cruise_speed_reg  <= CRUISE_RST;
            climb_speed_reg   <= CLIMB_RST;
            min_speed_reg     <= MIN_RST;
            max_speed_reg     <= MAX_RST;
            too_near_dist_reg <= NEAR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PLAN_IS_4D:    plan_is_4d_reg    <= cfg_data[0];
                REG_CRUISE_SPEED:  cruise_speed_reg  <= cfg_data[SPEED_W-1:0];
                REG_CLIMB_SPEED:   climb_speed_reg   <= cfg_data[SPEED_W-1:0];
                REG_MIN_SPEED:     min_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_MAX_SPEED:     max_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_TOO_NEAR_DIST: too_near_dist_reg <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Operand select for the current step
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (op_reg)
            OP_DX2:   begin op_a = A_W'(mag_x_reg);         op_b = B_W'(mag_x_reg);         end
            OP_DY2:   begin op_a = A_W'(mag_y_reg);         op_b = B_W'(mag_y_reg);         end
            OP_LHS:   begin op_a = A_W'(d2_reg);            op_b = B_W'(MILLION);           end
            OP_DT2:   begin op_a = A_W'(dt_reg);            op_b = B_W'(dt_reg);            end
            OP_MIN2:  begin op_a = A_W'(min_speed_reg);     op_b = B_W'(min_speed_reg);     end
            OP_SLOW:  begin op_a = A_W'(dt2_reg);           op_b = B_W'(t_reg);             end
            OP_MAX2:  begin op_a = A_W'(max_speed_reg);     op_b = B_W'(max_speed_reg);     end
            OP_FAST:  begin op_a = A_W'(dt2_reg);           op_b = B_W'(t_reg);             end
            OP_NEAR:  begin op_a = A_W'(too_near_dist_reg); op_b = B_W'(too_near_dist_reg); end
            OP_DZ2:   begin op_a = A_W'(mag_z_reg);         op_b = B_W'(mag_z_reg);         end
            OP_CR2:   begin op_a = A_W'(cruise_speed_reg);  op_b = B_W'(cruise_speed_reg);  end
            OP_RISE:  begin op_a = A_W'(dz2_reg);           op_b = B_W'(t_reg);             end
            OP_CL2:   begin op_a = A_W'(climb_speed_reg);   op_b = B_W'(climb_speed_reg);   end
            OP_ALLOW: begin op_a = A_W'(d2_reg);            op_b = B_W'(t_reg);             end
            default:  ;
        endcase
    end

    assign a_limb  = op_a[li_reg*LIMB_W +: LIMB_W];
    assign b_limb  = op_b[lj_reg*LIMB_W +: LIMB_W];
    assign shifted = SUM_W'(prod_reg) << {sh_reg, {LIMB_SH{1'b0}}};

    // End of a step: what follows, and the verdict where a test decides
    always_comb
    begin
        fin_op   = OP_DX2;
        fin_last = 1'b0;
        fin_code = CODE_OK;
        unique case (op_reg)
            OP_DX2:  fin_op = OP_DY2;
            OP_DY2:  fin_op = plan_is_4d_reg ? OP_LHS : OP_NEAR;
            OP_LHS:  fin_op = OP_DT2;
            OP_DT2:  fin_op = OP_MIN2;
            OP_MIN2: fin_op = OP_SLOW;
            OP_SLOW:
            begin
                if (ACC_W'(lhs_reg) < acc_reg)
                begin
                    fin_last = 1'b1;
                    fin_code = CODE_TIMING;
                end
                else
                begin
                    fin_op = OP_MAX2;
                end
            end
            OP_MAX2: fin_op = OP_FAST;
            OP_FAST:
            begin
                if (ACC_W'(lhs_reg) > acc_reg)
                begin
                    fin_last = 1'b1;
                    fin_code = CODE_TIMING;
                end
                else
                begin
                    fin_op = OP_NEAR;
                end
            end
            OP_NEAR:
            begin
                if (ACC_W'(d2_reg) < acc_reg)
                begin
                    fin_last = 1'b1;
                    fin_code = CODE_NEAR;
                end
                else
                begin
                    fin_op = OP_DZ2;
                end
            end
            OP_DZ2:  fin_op = OP_CR2;
            OP_CR2:  fin_op = OP_RISE;
            OP_RISE: fin_op = OP_CL2;
            OP_CL2:  fin_op = OP_ALLOW;
            OP_ALLOW:
            begin
                fin_last = 1'b1;
                fin_code = (ACC_W'(rise_reg) > acc_reg) ? CODE_STEEP : CODE_OK;
            end
            default: fin_last = 1'b1;
        endcase
    end

    // Plan verdict keeps the first nonzero code
    assign plan_code = (first_error_reg == CODE_OK) ? code_reg : first_error_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        issue_next       = issue_reg;
        pv_next          = 1'b0;
        li_next          = li_reg;
        lj_next          = lj_reg;
        code_next        = code_reg;
        checked_next     = checked_reg;
        first_error_next = first_error_reg;
        have_prev_next   = have_prev_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        // result taken downstream
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    have_prev_next = 1'b1;
                    state_next     = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (start_reg)
                begin
                    checked_next     = 1'b0;
                    code_next        = CODE_OK;
                    first_error_next = CODE_OK;
                    state_next       = ST_DONE;
                end
                else if (plan_is_4d_reg && !dt_pos_reg)
                begin
                    checked_next = 1'b1;
                    code_next    = CODE_TIMING;
                    state_next   = ST_DONE;
                end
                else
                begin
                    checked_next = 1'b1;
                    op_next      = OP_DX2;
                    issue_next   = 1'b1;
                    li_next      = '0;
                    lj_next      = 1'b0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                pv_next = issue_reg;
                if (issue_reg)
                begin
                    if (li_reg == LI_W'(A_LIMBS - 1))
                    begin
                        li_next = '0;
                        lj_next = ~lj_reg;
                        if (lj_reg)
                        begin
                            issue_next = 1'b0;
                        end
                    end
                    else
                    begin
                        li_next = li_reg + 1'b1;
                    end
                end
                else if (!pv_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_last)
                begin
                    code_next  = fin_code;
                    state_next = ST_DONE;
                end
                else
                begin
                    op_next    = fin_op;
                    issue_next = 1'b1;
                    li_next    = '0;
                    lj_next    = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next     = 1'b1;
                    m_data_next      = {3'b000, plan_code, code_reg, checked_reg};
                    first_error_next = plan_code;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_DX2;
            issue_reg       <= 1'b0;
            pv_reg          <= 1'b0;
            li_reg          <= '0;
            lj_reg          <= 1'b0;
            code_reg        <= CODE_OK;
            checked_reg     <= 1'b0;
            first_error_reg <= CODE_OK;
            have_prev_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            issue_reg       <= issue_next;
            pv_reg          <= pv_next;
            li_reg          <= li_next;
            lj_reg          <= lj_next;
            code_reg        <= code_next;
            checked_reg     <= checked_next;
            first_error_reg <= first_error_next;
            have_prev_reg   <= have_prev_next;
            m_valid_reg     <= m_valid_next;
            m_data_reg      <= m_data_next;
        end
    end

    // Waypoint capture: differences to the previous waypoint, then magnitudes
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dif_x_reg    <= {x_raw[MAG_W-1], x_raw} - {prev_x_reg[MAG_W-1], prev_x_reg};
            dif_y_reg    <= {y_raw[MAG_W-1], y_raw} - {prev_y_reg[MAG_W-1], prev_y_reg};
            dif_z_reg    <= {z_raw[MAG_W-1], z_raw} - {prev_z_reg[MAG_W-1], prev_z_reg};
            dt_reg       <= eta_raw - prev_eta_reg;
            dt_pos_reg   <= eta_raw > prev_eta_reg;
            start_reg    <= s_axis_tuser || !have_prev_reg;
            prev_x_reg   <= x_raw;
            prev_y_reg   <= y_raw;
            prev_z_reg   <= z_raw;
            prev_eta_reg <= eta_raw;
        end
        if (state_reg == ST_PREP)
        begin
            mag_x_reg <= dif_x_reg[DIF_W-1] ? MAG_W'(-dif_x_reg) : dif_x_reg[MAG_W-1:0];
            mag_y_reg <= dif_y_reg[DIF_W-1] ? MAG_W'(-dif_y_reg) : dif_y_reg[MAG_W-1:0];
            mag_z_reg <= dif_z_reg[DIF_W-1] ? MAG_W'(-dif_z_reg) : dif_z_reg[MAG_W-1:0];
        end
    end

    // Shared multiplier: limb product, then shifted accumulate
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL && issue_reg)
        begin
            prod_reg <= a_limb * b_limb;
            sh_reg   <= SH_W'(li_reg) + SH_W'(lj_reg);
        end

        if (state_reg == ST_PREP)
        begin
            acc_reg <= '0;
        end
        else if (state_reg == ST_MUL && pv_reg)
        begin
            acc_reg <= acc_reg + shifted[ACC_W-1:0];
        end
        else if (state_reg == ST_FIN && !fin_last && fin_op != OP_DY2)
        begin
            acc_reg <= '0;
        end

        // keep products that later steps use
        if (state_reg == ST_FIN)
        begin
            unique case (op_reg)
                OP_DY2:  d2_reg   <= acc_reg[D2_W-1:0];
                OP_LHS:  lhs_reg  <= acc_reg[LHS_W-1:0];
                OP_DT2:  dt2_reg  <= acc_reg[DT2_W-1:0];
                OP_MIN2: t_reg    <= acc_reg[T_W-1:0];
                OP_MAX2: t_reg    <= acc_reg[T_W-1:0];
                OP_DZ2:  dz2_reg  <= acc_reg[DZ2_W-1:0];
                OP_CR2:  t_reg    <= acc_reg[T_W-1:0];
                OP_RISE: rise_reg <= acc_reg[RISE_W-1:0];
                OP_CL2:  t_reg    <= acc_reg[T_W-1:0];
                default: ;
            endcase
        end
    end

    // Checks
    `WSFC_ASSERT_IMP(a_fin_drained, clk, rst_n, state_reg == ST_FIN, !issue_reg && !pv_reg)
    `WSFC_ASSERT_IMP(a_unchecked_zero, clk, rst_n, m_valid_reg && !m_data_reg[0], m_data_reg[4:1] == 4'd0)
    `WSFC_ASSERT_NXT(a_plan_sticky, clk, rst_n, state_reg != ST_PREP && first_error_reg != CODE_OK, first_error_reg == $past(first_error_reg))
    `WSFC_ASSERT_NXT(a_accept_prep, clk, rst_n, in_accept, state_reg == ST_PREP && !s_axis_tready)

endmodule
